>>> design/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

	localparam int unsigned GRAD_W     = 16;
	localparam int unsigned STRESS_W   = 24;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned DIVIDEND_W = 36;
	localparam int unsigned QUOT_W     = 24;
	localparam int unsigned PROD_SHIFT = 11;
	localparam int unsigned PADDR_W    = 3;

	localparam logic [CFG_W-1:0] SIGMA_RESET     = 16'd655;
	localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd16;

	typedef enum logic {
		REG_SURFACE_TENSION    = 1'b0,
		REG_GRADIENT_THRESHOLD = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
	} in_t;

	typedef struct packed {
		logic signed [STRESS_W-1:0] tau_xx;
		logic signed [STRESS_W-1:0] tau_xy;
		logic signed [STRESS_W-1:0] tau_yy;
		logic                       flat;
	} out_t;

endpackage

>>> design/cst_isqrt.sv
`timescale 1ns / 1ps
module cst_isqrt
	import cst_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	// one root bit per stage, remainder kept as sq - root^2
	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		localparam int unsigned K = ROOT_W - 1 - i;
		logic [SQ_W-1:0]   rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   trial;

		if (i == 0) begin : g_first
			assign rem_in  = sq;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		assign trial = (SQ_W'(root_in) << (K + 1)) + (SQ_W'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[i]  <= rem_in - trial;
					root_s[i] <= root_in | (ROOT_W'(1) << K);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

>>> design/cst_div.sv
`timescale 1ns / 1ps
module cst_div
	import cst_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [ROOT_W-1:0]     divisor,
	output logic [QUOT_W-1:0]     quotient
);

	logic [DIVIDEND_W-1:0] dvd_s [QUOT_W];
	logic [ROOT_W-1:0]     dvs_s [QUOT_W];
	logic [ROOT_W-1:0]     rem_s [QUOT_W];
	logic [QUOT_W-1:0]     quo_s [QUOT_W];

	// restoring division, one quotient bit per stage; quotient is known to fit
	for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
		localparam int unsigned J = QUOT_W - 1 - i;
		logic [DIVIDEND_W-1:0] dvd_in;
		logic [ROOT_W-1:0]     dvs_in;
		logic [ROOT_W-1:0]     rem_in;
		logic [QUOT_W-1:0]     quo_in;
		logic [ROOT_W:0]       shifted;

		if (i == 0) begin : g_first
			assign dvd_in = dividend;
			assign dvs_in = divisor;
			assign rem_in = ROOT_W'(dividend[DIVIDEND_W-1:QUOT_W]);
			assign quo_in = '0;
		end else begin : g_next
			assign dvd_in = dvd_s[i-1];
			assign dvs_in = dvs_s[i-1];
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign shifted = {rem_in, dvd_in[J]};

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[i] <= dvd_in;
				dvs_s[i] <= dvs_in;
				if (shifted >= {1'b0, dvs_in}) begin
					rem_s[i] <= ROOT_W'(shifted - {1'b0, dvs_in});
					quo_s[i] <= quo_in | (QUOT_W'(1) << J);
				end else begin
					rem_s[i] <= ROOT_W'(shifted);
					quo_s[i] <= quo_in;
				end
			end
		end
	end

	assign quotient = quo_s[QUOT_W-1];

endmodule

>>> design/capillary_stress_tensor.sv
`timescale 1ns / 1ps
// pipeline: 46 register stages, the result is held in the last one
// throughput: one transaction per cycle unless the output stalls; the norm square root
// takes 16 stages and the three parallel dividers 24 stages, one bit per stage
// a stall at the output holds the whole pipeline, nothing is dropped
// reset: asynchronous, clears valid bits; surface_tension 655, gradient_threshold 16
module capillary_stress_tensor
	import cst_pkg::*;
#(
	parameter logic [CFG_W-1:0] SIGMA_INIT     = SIGMA_RESET,
	parameter logic [CFG_W-1:0] THRESHOLD_INIT = THRESHOLD_RESET
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned SQRT_STAGES = ROOT_W;
	localparam int unsigned DIV_STAGES  = QUOT_W;
	localparam int unsigned NSTAGE      = 2 + SQRT_STAGES + 3 + DIV_STAGES + 1;

	typedef struct packed {
		logic                    flat;
		logic [30:0]             gxx;
		logic [30:0]             gyy;
		logic signed [SQ_W-1:0]  gxy;
	} side_t;

	typedef struct packed {
		logic flat;
		logic neg_xx;
		logic neg_xy;
		logic neg_yy;
	} sign_t;

	logic [CFG_W-1:0] sigma_q, thr_q;
	logic             en;
	logic [NSTAGE-1:0] valid_q;
	reg_sel_t         sel;

	// configuration port
	assign pready = 1'b1;
	assign sel    = reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_INIT;
			thr_q   <= THRESHOLD_INIT;
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_SURFACE_TENSION:    sigma_q <= pwdata[CFG_W-1:0];
				REG_GRADIENT_THRESHOLD: thr_q   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_SURFACE_TENSION:    prdata = {16'd0, sigma_q};
			REG_GRADIENT_THRESHOLD: prdata = {16'd0, thr_q};
			default:                prdata = '0;
		endcase
	end

	// global advance
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NSTAGE-2:0], in_valid};
		end
	end

	// s1: squares and cross product
	logic [30:0]            gxx_s1, gyy_s1;
	logic signed [SQ_W-1:0] gxy_s1;
	logic [SQ_W-1:0]        thr2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			gxx_s1  <= 31'(in_data.grad_x * in_data.grad_x);
			gyy_s1  <= 31'(in_data.grad_y * in_data.grad_y);
			gxy_s1  <= SQ_W'(in_data.grad_x * in_data.grad_y);
			thr2_s1 <= SQ_W'(thr_q * thr_q);
		end
	end

	// s2: squared norm and exact threshold test
	logic [SQ_W-1:0] sq_s2;
	side_t           side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2        <= SQ_W'(gxx_s1) + SQ_W'(gyy_s1);
			side_s2.flat <= (SQ_W'(gxx_s1) + SQ_W'(gyy_s1)) <= thr2_s1;
			side_s2.gxx  <= gxx_s1;
			side_s2.gyy  <= gyy_s1;
			side_s2.gxy  <= gxy_s1;
		end
	end

	logic [ROOT_W-1:0] root;
	side_t             side_d [SQRT_STAGES];

	cst_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sq   (sq_s2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s2;
			for (int i = 1; i < SQRT_STAGES; i++) side_d[i] <= side_d[i-1];
		end
	end

	// sa: norm squared
	logic [ROOT_W-1:0] n_sa;
	logic [SQ_W-1:0]   nn_sa;
	side_t             side_sa;

	always_ff @(posedge clk) begin
		if (en) begin
			n_sa    <= root;
			nn_sa   <= SQ_W'(root * root);
			side_sa <= side_d[SQRT_STAGES-1];
		end
	end

	// sb: tensor numerators as sign and magnitude
	logic signed [33:0] dxx, dyy;
	logic [ROOT_W-1:0]  n_sb;
	logic [SQ_W-1:0]    mxx_sb, mxy_sb, myy_sb;
	sign_t              sgn_sb;

	assign dxx = $signed({2'b00, nn_sa}) - $signed({3'b000, side_sa.gxx});
	assign dyy = $signed({2'b00, nn_sa}) - $signed({3'b000, side_sa.gyy});

	always_ff @(posedge clk) begin
		if (en) begin
			n_sb          <= n_sa;
			mxx_sb        <= SQ_W'(dxx[33] ? -dxx : dxx);
			myy_sb        <= SQ_W'(dyy[33] ? -dyy : dyy);
			mxy_sb        <= side_sa.gxy[SQ_W-1] ? SQ_W'(-side_sa.gxy) : SQ_W'(side_sa.gxy);
			sgn_sb.flat   <= side_sa.flat;
			sgn_sb.neg_xx <= dxx[33];
			sgn_sb.neg_yy <= dyy[33];
			sgn_sb.neg_xy <= !side_sa.gxy[SQ_W-1];
		end
	end

	// sc: scale by sigma, fold the 2^11 into the dividend
	logic [ROOT_W-1:0]     n_sc;
	logic [DIVIDEND_W-1:0] pxx_sc, pxy_sc, pyy_sc;
	sign_t                 sgn_sc;
	logic [47:0]           pxx, pxy, pyy;

	assign pxx = 48'(sigma_q) * 48'(mxx_sb);
	assign pxy = 48'(sigma_q) * 48'(mxy_sb);
	assign pyy = 48'(sigma_q) * 48'(myy_sb);

	always_ff @(posedge clk) begin
		if (en) begin
			n_sc   <= n_sb;
			pxx_sc <= DIVIDEND_W'(pxx >> PROD_SHIFT);
			pxy_sc <= DIVIDEND_W'(pxy >> PROD_SHIFT);
			pyy_sc <= DIVIDEND_W'(pyy >> PROD_SHIFT);
			sgn_sc <= sgn_sb;
		end
	end

	logic [QUOT_W-1:0] qxx, qxy, qyy;
	sign_t             sgn_d [DIV_STAGES];

	cst_div u_div_xx (.clk(clk), .en(en), .dividend(pxx_sc), .divisor(n_sc), .quotient(qxx));
	cst_div u_div_xy (.clk(clk), .en(en), .dividend(pxy_sc), .divisor(n_sc), .quotient(qxy));
	cst_div u_div_yy (.clk(clk), .en(en), .dividend(pyy_sc), .divisor(n_sc), .quotient(qyy));

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_d[0] <= sgn_sc;
			for (int i = 1; i < DIV_STAGES; i++) sgn_d[i] <= sgn_d[i-1];
		end
	end

	// output register: restore signs, zero flat nodes
	sign_t sgn_o;
	out_t  res_q;

	assign sgn_o = sgn_d[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.flat <= sgn_o.flat;
			if (sgn_o.flat) begin
				res_q.tau_xx <= '0;
				res_q.tau_xy <= '0;
				res_q.tau_yy <= '0;
			end else begin
				res_q.tau_xx <= STRESS_W'(sgn_o.neg_xx ? -qxx : qxx);
				res_q.tau_xy <= STRESS_W'(sgn_o.neg_xy ? -qxy : qxy);
				res_q.tau_yy <= STRESS_W'(sgn_o.neg_yy ? -qyy : qyy);
			end
		end
	end

	assign out_data = res_q;

endmodule

>>> tb/sv/capillary_stress_tensor_tb.sv
`timescale 1ns / 1ps
module capillary_stress_tensor_tb
	import cst_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 60;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_t                in_data;
	logic               out_valid;
	logic               out_ready;
	out_t               out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	logic [CFG_W-1:0] sigma_cfg;
	logic [CFG_W-1:0] thresh_cfg;
	out_t             stress_due[$];
	int unsigned      mismatches;
	int unsigned      cycles;
	int unsigned      rx_hold;
	bit               tx_gaps;
	bit               rx_gaps;

	capillary_stress_tensor DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned norm_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 32;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic out_t stress_of(in_t g);
		out_t   o;
		longint gx, gy, gxx, gyy, sq, thr, s, n, den, nn;
		longint xx, xy, yy;
		gx  = longint'(g.grad_x);
		gy  = longint'(g.grad_y);
		gxx = gx * gx;
		gyy = gy * gy;
		sq  = gxx + gyy;
		thr = longint'(thresh_cfg);
		o   = '0;
		if (sq <= thr * thr) begin
			o.flat = 1'b1;
			return o;
		end
		s   = longint'(sigma_cfg);
		n   = longint'(norm_floor(longint'(sq)));
		den = n * 2048;
		nn  = n * n;
		// signed division truncates toward zero
		xx  = (s * (nn - gxx)) / den;
		xy  = (-(s * (gx * gy))) / den;
		yy  = (s * (nn - gyy)) / den;
		o.tau_xx = xx[STRESS_W-1:0];
		o.tau_xy = xy[STRESS_W-1:0];
		o.tau_yy = yy[STRESS_W-1:0];
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (stress_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %h", out_data);
			end else begin
				e = stress_due.pop_front();
				if (e.tau_xx !== out_data.tau_xx || e.tau_xy !== out_data.tau_xy ||
				    e.tau_yy !== out_data.tau_yy || e.flat !== out_data.flat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch xx %h/%h xy %h/%h yy %h/%h flat %b/%b (exp/act)",
							e.tau_xx, out_data.tau_xx, e.tau_xy, out_data.tau_xy,
							e.tau_yy, out_data.tau_yy, e.flat, out_data.flat);
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				rx_hold = $urandom_range(0, 13);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("capillary_stress_tensor_tb: errors");
			$finish;
		end
	end

	task automatic send_grad(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
		in_t g;
		g.grad_x = gx;
		g.grad_y = gy;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= g;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		stress_due.push_back(stress_of(g));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (stress_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(reg_sel_t r, logic [CFG_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({r, 2'b00});
		pwdata  <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (r == REG_SURFACE_TENSION)
			sigma_cfg = v;
		else
			thresh_cfg = v;
	endtask

	task automatic send_random(int unsigned count);
		logic signed [GRAD_W-1:0] gx, gy;
		logic [GRAD_W-1:0]        lim;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: begin
					gx = GRAD_W'($urandom);
					gy = GRAD_W'($urandom);
				end
				1: begin
					// close to the threshold circle
					lim = (thresh_cfg > 16'd16000) ? 16'd32767 : thresh_cfg + 16'd4;
					gx = GRAD_W'($urandom_range(0, lim));
					gy = GRAD_W'($urandom_range(0, lim));
					if ($urandom_range(0, 1)) gx = -gx;
					if ($urandom_range(0, 1)) gy = -gy;
				end
				2: begin
					gx = GRAD_W'($urandom);
					gy = GRAD_W'($urandom_range(0, 3)) - 16'sd1;
				end
				default: begin
					gx = GRAD_W'($urandom_range(0, 511)) - 16'sd256;
					gy = GRAD_W'($urandom_range(0, 511)) - 16'sd256;
				end
			endcase
			send_grad(gx, gy);
		end
	endtask

	task automatic test_directed;
		send_grad(16'sd0, 16'sd0);
		send_grad(-16'sd32768, -16'sd32768);
		send_grad(16'sd32767, 16'sd32767);
		send_grad(-16'sd32768, 16'sd32767);
		send_grad(16'sd32767, -16'sd32768);
		send_grad(-16'sd32768, 16'sd0);
		send_grad(16'sd0, 16'sd32767);
		send_grad(16'sd16, 16'sd0);     // exactly on the threshold
		send_grad(16'sd0, -16'sd16);
		send_grad(16'sd17, 16'sd0);
		send_grad(16'sd11, 16'sd11);
		send_grad(16'sd12, -16'sd12);
		send_grad(16'sd1000, 16'sd1);   // norm rounded down to exactly gx
		send_grad(-16'sd3, 16'sd16384);
		send_grad(16'sd16384, 16'sd16384);
		send_grad(16'sd1, -16'sd1);
		drain();
	endtask

	task automatic test_config_sweep;
		write_reg(REG_SURFACE_TENSION, 16'hFFFF);
		write_reg(REG_GRADIENT_THRESHOLD, 16'd0);
		send_grad(16'sd0, 16'sd0);
		send_grad(16'sd1, 16'sd0);
		send_grad(-16'sd32768, -16'sd32768);
		send_random(80);
		drain();
		write_reg(REG_SURFACE_TENSION, 16'd0);
		write_reg(REG_GRADIENT_THRESHOLD, 16'hFFFF);
		send_grad(-16'sd32768, -16'sd32768);
		send_random(40);
		drain();
		write_reg(REG_GRADIENT_THRESHOLD, 16'd300);
		send_random(60);
		drain();
		write_reg(REG_SURFACE_TENSION, 16'd40000);
		write_reg(REG_GRADIENT_THRESHOLD, 16'd5000);
		send_random(60);
		drain();
	endtask

	task automatic test_random;
		write_reg(REG_SURFACE_TENSION, 16'($urandom));
		write_reg(REG_GRADIENT_THRESHOLD, 16'($urandom_range(0, 2000)));
		send_random(350);
		drain();
	endtask

	task automatic test_backpressure;
		tx_gaps = 1'b0;
		rx_hold = 400;
		send_random(150);
		drain();
	endtask

	task automatic test_steady_stream;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_reg(REG_SURFACE_TENSION, 16'd655);
		write_reg(REG_GRADIENT_THRESHOLD, 16'd16);
		send_random(200);
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		sigma_cfg  = SIGMA_RESET;
		thresh_cfg = THRESHOLD_RESET;
		mismatches = 0;
		cycles     = 0;
		rx_hold    = 0;
		tx_gaps    = 1'b1;
		rx_gaps    = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		test_backpressure();
		test_steady_stream();
		if (mismatches == 0)
			$display("capillary_stress_tensor_tb: clean");
		else
			$display("capillary_stress_tensor_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
design/cst_pkg.sv
design/cst_isqrt.sv
design/cst_div.sv
design/capillary_stress_tensor.sv
tb/sv/capillary_stress_tensor_tb.sv
